// ===== hdl/lts_pkg.sv =====
// shared constants, types, microcode encodings and constant tables for the letter tone synthesizer
`default_nettype none

package lts_pkg;

  // fixed design constants
  localparam int MAX_HARMONICS = 10;
  localparam int SINE_DEPTH    = 1024;
  localparam int PHASE_BITS    = 32;
  localparam int SAMPLE_RATE   = 44100;
  localparam int SINE_AW       = $clog2(SINE_DEPTH);

  // field and register widths
  localparam int CHAR_W    = 8;
  localparam int SAMPLE_W  = 16;
  localparam int LEN_W     = 16;
  localparam int HARM_W    = 4;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  // datapath widths
  localparam int ROM_W     = 17;  // sine entry, peak reaches +32768
  localparam int WEIGHT_W  = 17;
  localparam int ENV_W     = 17;
  localparam int MUL_W     = 18;
  localparam int PROD_W    = 35;
  localparam int ACC_W     = 34;
  localparam int MAG_W     = 33;
  localparam int M_W       = 34;
  localparam int NUM_W     = 34;
  localparam int SCALED_W  = 18;
  localparam int SCALE_W   = M_W + 15;
  localparam int DIV_K_W   = $clog2(ENV_W);
  localparam int NUM_PITCH = 26;
  localparam int PITCH_W   = 5;

  localparam logic [DIV_K_W-1:0] DIV_K_INIT = DIV_K_W'(ENV_W - 1);

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TONE_SAMPLES    = 2'd0,
    REG_SILENCE_SAMPLES = 2'd1,
    REG_HARMONIC_COUNT  = 2'd2
  } cfg_reg_t;

  localparam logic [LEN_W-1:0]  TONE_SAMPLES_RST    = 16'd4410;
  localparam logic [LEN_W-1:0]  SILENCE_SAMPLES_RST = 16'd8820;
  localparam logic [HARM_W-1:0] HARMONIC_COUNT_RST  = 4'd10;
  localparam logic [HARM_W-1:0] HARM_LIMIT          = HARM_W'(MAX_HARMONICS);

  // request kinds
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  // character codes
  localparam logic [CHAR_W-1:0] LOWER_A     = 8'd97;
  localparam logic [CHAR_W-1:0] LOWER_Z     = 8'd122;
  localparam logic [CHAR_W-1:0] UPPER_A     = 8'd65;
  localparam logic [CHAR_W-1:0] UPPER_Z     = 8'd90;
  localparam logic [CHAR_W-1:0] CASE_OFFSET = 8'd32;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

  // microcode
  localparam int PC_W        = 4;
  localparam int UCODE_DEPTH = 1 << PC_W;

  typedef logic [PC_W-1:0] upc_t;

  localparam upc_t PC_IDLE     = 4'd0;
  localparam upc_t PC_HARM     = 4'd1;
  localparam upc_t PC_HARM_MUL = 4'd2;
  localparam upc_t PC_HARM_ACC = 4'd3;
  localparam upc_t PC_DIV      = 4'd4;
  localparam upc_t PC_MAG      = 4'd5;
  localparam upc_t PC_MUL_HI   = 4'd6;
  localparam upc_t PC_MUL_LO   = 4'd7;
  localparam upc_t PC_ADD_LO   = 4'd8;
  localparam upc_t PC_SCALE    = 4'd9;
  localparam upc_t PC_SAT      = 4'd10;
  localparam upc_t PC_OUT_WAIT = 4'd11;
  localparam upc_t PC_EMIT     = 4'd12;

  typedef enum logic [3:0] {
    OP_NOP      = 4'd0,
    OP_MUL_HARM = 4'd1,
    OP_ACC      = 4'd2,
    OP_DIV      = 4'd3,
    OP_MAG      = 4'd4,
    OP_MUL_HI   = 4'd5,
    OP_MUL_LO   = 4'd6,
    OP_ADD_LO   = 4'd7,
    OP_SCALE    = 4'd8,
    OP_SAT      = 4'd9,
    OP_EMIT     = 4'd10
  } dp_op_t;

  typedef enum logic [2:0] {
    JC_NEXT      = 3'd0,
    JC_ALWAYS    = 3'd1,
    JC_NO_START  = 3'd2,
    JC_HARM_DONE = 3'd3,
    JC_DIV_MORE  = 3'd4,
    JC_OUT_BUSY  = 3'd5
  } jump_cond_t;

  typedef struct packed {
    dp_op_t     op;
    jump_cond_t cond;
    upc_t       target;
  } uword_t;

  // datapath status seen by the sequencer
  typedef struct packed {
    logic harm_done;
    logic div_more;
  } dp_flags_t;

  // per-sample operands loaded when a tick starts
  typedef struct packed {
    logic [PHASE_BITS-1:0] bp;
    logic [HARM_W-1:0]     h_eff;
    logic [NUM_W-1:0]      div_num;
    logic [LEN_W-1:0]      len;
    logic                  in_range;
  } dp_init_t;

  // pitch table: phase increment per sample for each letter
  localparam logic [63:0] Q30_ONE         = 64'd1 << 30;
  localparam logic [63:0] POW_LIMIT       = 64'd1 << 32;
  localparam logic [63:0] HALF_PI_Q30     = 64'd1686629713;
  localparam logic [63:0] RATIO_SEARCH_HI = 64'd1105954079;
  localparam logic [63:0] STEP_DEN        = 64'(SAMPLE_RATE) << 22;
  localparam logic [63:0] BASE_HZ         = 64'd110;

  // 26-fold truncated q30 power, frozen once above 4.0
  function automatic logic [63:0] pow26_q30(input logic [63:0] x);
    logic [63:0] p;
    p = Q30_ONE;
    for (int i = 0; i < NUM_PITCH; i++) begin
      if (p <= POW_LIMIT) p = (p * x) >> 30;
    end
    return p;
  endfunction

  // largest q30 ratio whose 26th power stays at or below 2.0
  function automatic logic [63:0] ratio_q30();
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    lo = Q30_ONE;
    hi = RATIO_SEARCH_HI;
    for (int i = 0; i < 40; i++) begin
      if (lo < hi) begin
        mid = lo + ((hi - lo + 64'd1) >> 1);
        if (pow26_q30(mid) <= (Q30_ONE << 1)) lo = mid;
        else hi = mid - 64'd1;
      end
    end
    return lo;
  endfunction

  localparam logic [63:0] RATIO_Q30 = ratio_q30();

  typedef logic [(1 << PITCH_W)-1:0][PHASE_BITS-1:0] step_tab_t;

  function automatic step_tab_t make_step_tab();
    step_tab_t   tab;
    logic [63:0] r;
    logic [63:0] num;
    r = Q30_ONE;
    for (int k = 0; k < (1 << PITCH_W); k++) begin
      if (k < NUM_PITCH) begin
        num = (BASE_HZ * r) << (PHASE_BITS - 8);
        tab[k] = PHASE_BITS'((num + (STEP_DEN >> 1)) / STEP_DEN);
      end else begin
        tab[k] = '0;
      end
      r = (r * RATIO_Q30 + (Q30_ONE >> 1)) >> 30;
    end
    return tab;
  endfunction

  localparam step_tab_t STEP_TAB = make_step_tab();

  // quarter-wave sine in q30 by taylor series
  function automatic logic [63:0] sin_q30(input logic [63:0] x);
    logic signed [63:0] s;
    logic [63:0]        t;
    s = signed'(x);
    t = x;
    for (int n = 1; n <= 8; n++) begin
      t = (t * x) >> 30;
      t = (t * x) >> 30;
      t = t / 64'((2 * n) * (2 * n + 1));
      if (n[0]) s = s - signed'(t);
      else s = s + signed'(t);
    end
    return (s < 0) ? 64'd0 : unsigned'(s);
  endfunction

  typedef logic [SINE_DEPTH-1:0][ROM_W-1:0] sine_tab_t;

  function automatic sine_tab_t make_sine_tab();
    sine_tab_t   tab;
    logic [63:0] a;
    logic [63:0] quad;
    logic [63:0] rem;
    logic [63:0] x;
    logic [63:0] v;
    for (int i = 0; i < SINE_DEPTH; i++) begin
      a    = 64'(i) * 64'd4;
      quad = a / 64'(SINE_DEPTH);
      rem  = a % 64'(SINE_DEPTH);
      if (quad[0]) rem = 64'(SINE_DEPTH) - rem;
      x = (rem * HALF_PI_Q30 + 64'(SINE_DEPTH / 2)) / 64'(SINE_DEPTH);
      v = (sin_q30(x) + 64'd16384) >> 15;
      tab[i] = quad[1] ? ROM_W'(-v) : ROM_W'(v);
    end
    return tab;
  endfunction

  // harmonic weight round(65536 / n) in q16
  function automatic logic [WEIGHT_W-1:0] harm_weight(input logic [HARM_W-1:0] n);
    logic [WEIGHT_W-1:0] w;
    case (n)
      4'd1:    w = 17'd65536;
      4'd2:    w = 17'd32768;
      4'd3:    w = 17'd21845;
      4'd4:    w = 17'd16384;
      4'd5:    w = 17'd13107;
      4'd6:    w = 17'd10923;
      4'd7:    w = 17'd9362;
      4'd8:    w = 17'd8192;
      4'd9:    w = 17'd7282;
      4'd10:   w = 17'd6554;
      4'd11:   w = 17'd5958;
      4'd12:   w = 17'd5461;
      4'd13:   w = 17'd5041;
      4'd14:   w = 17'd4681;
      4'd15:   w = 17'd4369;
      default: w = 17'd0;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/lts_stream_if.sv =====
// valid/ready channel interfaces for command beats and audio beats
`default_nettype none

interface lts_cmd_if import lts_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              req_type;
  logic [CHAR_W-1:0] char_code;

  modport source (output valid, output req_type, output char_code, input ready);
  modport sink (input valid, input req_type, input char_code, output ready);
endinterface

interface lts_audio_if import lts_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       last;

  modport source (output valid, output sample, output last, input ready);
  modport sink (input valid, input sample, input last, output ready);
endinterface

`default_nettype wire

// ===== hdl/letter_tone_synthesizer.sv =====
// top level: configuration registers, tone state, channel handshakes and output register
//
// letter tone synthesizer
// cmd channel: a beat with req_type load takes char_code; a letter (either case) starts
// a tone whose pitch steps through a 26-step octave from 110 Hz, any other byte starts a
// run of zero samples. a beat with req_type tick asks for one sample.
// audio channel: one beat per tick while a tone or gap runs, last set on its final
// sample. ticks while nothing runs are taken and give no beat.
// config port: cfg_we writes cfg_data to the register at cfg_index (tone_samples,
// silence_samples, harmonic_count); other indexes are ignored. write only while idle.
// sequencing: loads and idle ticks leave the sequencer idle. a running tick is taken, then the
// microcode sequencer steps through each harmonic on the single sine rom and the shared
// 18x18 multiplier, then through the bit-serial envelope divider and the scaling steps,
// holds while the audio slot is full and emits the beat; the next cmd beat is taken only
// once the sequencer is back in its idle state
// reset: synchronous; configuration and tone registers return to their defaults and the block goes idle
// stall: cmd.ready stays high while a finished beat waits on audio; a following tick
// runs to its end and then holds until the audio slot frees up
`default_nettype none

module letter_tone_synthesizer import lts_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  lts_cmd_if.sink              cmd,
  lts_audio_if.source          audio,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  // configuration
  logic [LEN_W-1:0]      tone_samples;
  logic [LEN_W-1:0]      silence_samples;
  logic [HARM_W-1:0]     harmonic_count;

  // tone state
  logic [PHASE_BITS-1:0] base_phase;
  logic [PHASE_BITS-1:0] phase_step;
  logic [LEN_W-1:0]      sample_index;
  logic                  is_silence;
  logic                  active;
  logic                  last_q;

  // handshake and sequencing
  logic                  cmd_beat;
  logic                  is_tick;
  logic                  start;
  logic                  out_busy;
  logic                  seq_idle;
  dp_op_t                op;
  dp_flags_t             dp_flags;
  dp_init_t              dp_init;
  logic signed [SAMPLE_W-1:0] dp_sample;

  // per-beat decode
  logic [CHAR_W-1:0]     ch;
  logic                  letter;
  logic [PITCH_W-1:0]    pitch_idx;
  logic [LEN_W-1:0]      len_sel;
  logic [LEN_W-1:0]      run_len;
  logic [LEN_W:0]        idx_inc;
  logic                  is_last;
  logic                  first_half;
  logic [LEN_W-1:0]      env_arg;

  assign cmd.ready = seq_idle;
  assign cmd_beat  = cmd.valid && cmd.ready;
  assign is_tick   = (cmd.req_type == REQ_TICK);
  assign start     = cmd_beat && is_tick && active;
  assign out_busy  = audio.valid && !audio.ready;

  always_comb begin
    // fold lower case to upper case, then pick the pitch
    ch = cmd.char_code;
    if (ch inside {[LOWER_A:LOWER_Z]}) ch = ch - CASE_OFFSET;
    letter    = ch inside {[UPPER_A:UPPER_Z]};
    pitch_idx = PITCH_W'(ch - UPPER_A);

    // run length of the current tone or gap, zero counts as one
    len_sel = is_silence ? silence_samples : tone_samples;
    run_len = (len_sel == '0) ? LEN_W'(1) : len_sel;
    idx_inc = {1'b0, sample_index} + (LEN_W+1)'(1);
    is_last = (idx_inc >= {1'b0, run_len});

    // triangle envelope: rising half uses i, falling half uses len - i
    first_half = ({sample_index, 1'b0} < {1'b0, run_len});
    env_arg    = first_half ? sample_index : run_len - sample_index;

    dp_init.bp       = base_phase;
    dp_init.h_eff    = is_silence ? '0 :
                       (harmonic_count > HARM_LIMIT) ? HARM_LIMIT : harmonic_count;
    dp_init.div_num  = NUM_W'({env_arg, 17'b0}) + NUM_W'(run_len >> 1);
    dp_init.len      = run_len;
    dp_init.in_range = (sample_index < run_len);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tone_samples    <= TONE_SAMPLES_RST;
      silence_samples <= SILENCE_SAMPLES_RST;
      harmonic_count  <= HARMONIC_COUNT_RST;
      base_phase      <= '0;
      phase_step      <= '0;
      sample_index    <= '0;
      is_silence      <= 1'b0;
      active          <= 1'b0;
      audio.valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_TONE_SAMPLES:    tone_samples    <= cfg_data;
          REG_SILENCE_SAMPLES: silence_samples <= cfg_data;
          REG_HARMONIC_COUNT:  harmonic_count  <= cfg_data[HARM_W-1:0];
          default: ;
        endcase
      end

      if (audio.valid && audio.ready) audio.valid <= 1'b0;
      if (op == OP_EMIT) audio.valid <= 1'b1;

      if (cmd_beat) begin
        if (!is_tick) begin
          // a load replaces whatever runs
          base_phase   <= '0;
          sample_index <= '0;
          active       <= 1'b1;
          is_silence   <= !letter;
          phase_step   <= letter ? STEP_TAB[pitch_idx] : '0;
        end else if (active) begin
          sample_index <= LEN_W'(idx_inc);
          base_phase   <= base_phase + phase_step;
          if (is_last) active <= 1'b0;
        end
      end
    end
  end

  // output payload and the last flag of the tick in flight
  always_ff @(posedge clk) begin
    if (start) last_q <= is_last;
    if (op == OP_EMIT) begin
      audio.sample <= dp_sample;
      audio.last   <= last_q;
    end
  end

  lts_sequencer u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .out_busy (out_busy),
    .flags    (dp_flags),
    .op       (op),
    .idle     (seq_idle)
  );

  lts_datapath u_dp (
    .clk    (clk),
    .op     (op),
    .start  (start),
    .init   (dp_init),
    .flags  (dp_flags),
    .sample (dp_sample)
  );

endmodule

`default_nettype wire

// ===== hdl/lts_sequencer.sv =====
// microcode step counter, program rom and jump logic
`default_nettype none

module lts_sequencer import lts_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  logic      out_busy,
  input  dp_flags_t flags,
  output dp_op_t    op,
  output logic      idle
);

  localparam uword_t PROGRAM [UCODE_DEPTH] = '{
    '{OP_NOP,      JC_NO_START,  PC_IDLE},      // wait for a tick
    '{OP_NOP,      JC_HARM_DONE, PC_DIV},       // sine rom read
    '{OP_MUL_HARM, JC_NEXT,      PC_IDLE},      // sine times weight
    '{OP_ACC,      JC_ALWAYS,    PC_HARM},      // add to harmonic sum
    '{OP_DIV,      JC_DIV_MORE,  PC_DIV},       // one envelope quotient bit
    '{OP_MAG,      JC_NEXT,      PC_IDLE},
    '{OP_MUL_HI,   JC_NEXT,      PC_IDLE},
    '{OP_MUL_LO,   JC_NEXT,      PC_IDLE},
    '{OP_ADD_LO,   JC_NEXT,      PC_IDLE},
    '{OP_SCALE,    JC_NEXT,      PC_IDLE},
    '{OP_SAT,      JC_NEXT,      PC_IDLE},
    '{OP_NOP,      JC_OUT_BUSY,  PC_OUT_WAIT},  // hold while output slot full
    '{OP_EMIT,     JC_ALWAYS,    PC_IDLE},
    '{OP_NOP,      JC_ALWAYS,    PC_IDLE},
    '{OP_NOP,      JC_ALWAYS,    PC_IDLE},
    '{OP_NOP,      JC_ALWAYS,    PC_IDLE}
  };

  upc_t   pc;
  upc_t   pc_next;
  uword_t word;
  logic   take;

  assign word = PROGRAM[pc];
  assign op   = word.op;
  assign idle = (pc == PC_IDLE);

  always_comb begin
    case (word.cond)
      JC_NEXT:      take = 1'b0;
      JC_ALWAYS:    take = 1'b1;
      JC_NO_START:  take = !start;
      JC_HARM_DONE: take = flags.harm_done;
      JC_DIV_MORE:  take = flags.div_more;
      JC_OUT_BUSY:  take = out_busy;
      default:      take = 1'b1;
    endcase
    pc_next = take ? word.target : pc + upc_t'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= PC_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/lts_datapath.sv =====
// harmonic sum, envelope divider, shared multiplier and output scaling
`default_nettype none

module lts_datapath import lts_pkg::*; (
  input  logic                       clk,
  input  dp_op_t                     op,
  input  logic                       start,
  input  dp_init_t                   init,
  output dp_flags_t                  flags,
  output logic signed [SAMPLE_W-1:0] sample
);

  localparam sine_tab_t SINE_TAB = make_sine_tab();

  logic        [PHASE_BITS-1:0]  bp;
  logic        [PHASE_BITS-1:0]  hp;
  logic        [HARM_W-1:0]      n;
  logic        [HARM_W-1:0]      h_eff;
  logic signed [ROM_W-1:0]       rom_q;
  logic signed [PROD_W-1:0]      prod;
  logic signed [ACC_W-1:0]       acc;
  logic        [NUM_W-1:0]       rem;
  logic        [ENV_W-1:0]       quo;
  logic        [DIV_K_W-1:0]     k;
  logic        [LEN_W-1:0]       len_r;
  logic                          in_range;
  logic                          neg;
  logic        [MAG_W-1:0]       mag;
  logic        [ENV_W-1:0]       env;
  logic        [M_W-1:0]         m;
  logic        [SCALED_W-1:0]    scaled;
  logic signed [SAMPLE_W-1:0]    res;

  logic signed [MUL_W-1:0]       mul_a;
  logic signed [MUL_W-1:0]       mul_b;
  logic signed [2*MUL_W-1:0]     mul_p;
  logic        [NUM_W-1:0]       dsh;
  logic                          ge;
  logic        [SCALE_W-1:0]     wide;

  assign flags.harm_done = (n > h_eff);
  assign flags.div_more  = (k != '0);
  assign sample          = res;

  // sine rom, registered read at the current harmonic phase
  always_ff @(posedge clk) begin
    rom_q <= signed'(SINE_TAB[hp[PHASE_BITS-1 -: SINE_AW]]);
  end

  always_comb begin
    case (op)
      OP_MUL_HARM: begin
        mul_a = MUL_W'(rom_q);
        mul_b = signed'({1'b0, harm_weight(n)});
      end
      OP_MUL_HI: begin
        mul_a = signed'({1'b0, mag[MAG_W-1:16]});
        mul_b = signed'({1'b0, env});
      end
      OP_MUL_LO: begin
        mul_a = signed'({2'b00, mag[15:0]});
        mul_b = signed'({1'b0, env});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;
  assign dsh   = NUM_W'(len_r) << k;
  assign ge    = (rem >= dsh);
  assign wide  = {m, 15'b0} - SCALE_W'(m);

  always_ff @(posedge clk) begin
    if (start) begin
      bp       <= init.bp;
      hp       <= init.bp;
      n        <= HARM_W'(1);
      h_eff    <= init.h_eff;
      acc      <= '0;
      rem      <= init.div_num;
      quo      <= '0;
      k        <= DIV_K_INIT;
      len_r    <= init.len;
      in_range <= init.in_range;
    end else begin
      case (op)
        OP_MUL_HARM: begin
          prod <= PROD_W'(mul_p);
          hp   <= hp + bp;
          n    <= n + HARM_W'(1);
        end
        OP_ACC: begin
          acc <= acc + ACC_W'(prod);
        end
        OP_DIV: begin
          if (ge) rem <= rem - dsh;
          quo <= {quo[ENV_W-2:0], ge};
          k   <= k - DIV_K_W'(1);
        end
        OP_MAG: begin
          neg <= acc[ACC_W-1];
          mag <= acc[ACC_W-1] ? MAG_W'(-acc) : MAG_W'(acc);
          env <= in_range ? quo : '0;
        end
        OP_MUL_HI: begin
          prod <= PROD_W'(mul_p);
        end
        OP_MUL_LO: begin
          m    <= M_W'(prod);
          prod <= PROD_W'(mul_p);
        end
        OP_ADD_LO: begin
          m <= m + M_W'(prod[PROD_W-1:16]);
        end
        OP_SCALE: begin
          // times 32767 then drop 31 fraction bits
          scaled <= wide[SCALE_W-1:31];
        end
        OP_SAT: begin
          if (neg) begin
            res <= (scaled >= SCALED_W'(32768)) ? SAMPLE_MIN : SAMPLE_W'(-scaled);
          end else begin
            res <= (scaled > SCALED_W'(SAMPLE_MAX)) ? SAMPLE_MAX : SAMPLE_W'(scaled);
          end
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hdl/lts_checker.sv =====
// port-level assertions for the letter tone synthesizer and their bind
`default_nettype none

module lts_checker import lts_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                cmd_valid,
  input logic                cmd_ready,
  input logic                cmd_req_type,
  input logic                audio_valid,
  input logic                audio_ready,
  input logic [SAMPLE_W-1:0] audio_sample,
  input logic                audio_last
);

  // a stalled audio beat stays up
  a_audio_hold: assert property (@(posedge clk) disable iff (rst)
    audio_valid && !audio_ready |=> audio_valid)
    else $error("audio beat dropped while stalled");

  // a stalled audio beat keeps its payload
  a_audio_stable: assert property (@(posedge clk) disable iff (rst)
    audio_valid && !audio_ready |=> $stable(audio_sample) && $stable(audio_last))
    else $error("audio payload changed while stalled");

  // a load never produces a sample
  a_load_quiet: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready && (cmd_req_type == REQ_LOAD) && !audio_valid |=> !audio_valid)
    else $error("audio beat right after a load");

  // a new sample only comes out of a running tick, when commands are held off
  a_emit_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(audio_valid) |-> !$past(cmd_ready))
    else $error("audio beat appeared while sequencer was idle");

endmodule

bind letter_tone_synthesizer lts_checker u_lts_checker (
  .clk          (clk),
  .rst          (rst),
  .cmd_valid    (cmd.valid),
  .cmd_ready    (cmd.ready),
  .cmd_req_type (cmd.req_type),
  .audio_valid  (audio.valid),
  .audio_ready  (audio.ready),
  .audio_sample (audio.sample),
  .audio_last   (audio.last)
);

`default_nettype wire
